@@ rtl/core/sbda_pkg.sv @@
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ascii printer.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned CountW     = 5;

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_MOVE
  } sbda_cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } sbda_state_e;

endpackage

@@ rtl/core/sbda_cell.sv @@
// ----------------------------------------------------------------------------
// sbda_cell
// One decimal digit of the conversion chain: add-3 correction and shift
// during conversion, digit move toward the top while dropping leading zeros and during output.
// ----------------------------------------------------------------------------
module sbda_cell (
  input  logic                  clk_i,
  input  sbda_pkg::sbda_cell_op_e op_i,
  input  logic                  bit_i,
  input  logic [3:0]            digit_i,
  output logic                  bit_o,
  output logic [3:0]            digit_o
);
  import sbda_pkg::*;

  logic [3:0] digit_q;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_HOLD:   digit_q <= digit_q;
      CELL_CLEAR:  digit_q <= 4'd0;
      CELL_DABBLE: digit_q <= {adj[2:0], bit_i};
      CELL_MOVE:   digit_q <= digit_i;
      default:     digit_q <= digit_q;
    endcase
  end

endmodule

@@ rtl/core/signed_binary_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Prints a signed 64-bit integer as decimal ascii text, one character per
// strobe, most significant digit first, with a leading minus when negative.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+----------------------
//   request  | value_i                                | start && !busy
//   result   | char_code_o, last_o, char_count_o      | strobe_o, one cycle
//
// A request runs double dabble over all 64 bits through a chain of 20 digit
// cells, then drops leading zeros, then takes one cycle per character
// (up to 20); each character is registered before it shows on the ports.
// busy is high until the last character is registered.
// Reset clears the controller and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [sbda_pkg::ValueWidth-1:0] value_i,
  output logic                             strobe_o,
  output logic [7:0]                       char_code_o,
  output logic                             last_o,
  output logic [sbda_pkg::CountW-1:0]      char_count_o
);
  import sbda_pkg::*;

  sbda_state_e state_q, state_d;
  sbda_cell_op_e cell_op;

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [BitCntW-1:0]    bits_q, bits_d;
  logic                  neg_q, neg_d;
  logic [CountW-1:0]     rem_q, rem_d;
  logic [CountW-1:0]     total_q, total_d;

  logic                  strobe_d;
  logic [7:0]            char_d;
  logic                  last_d;
  logic [CountW-1:0]     count_d;
  logic                  load_out;

  logic                  carry [NumDigits+1];
  logic [3:0]            dig   [NumDigits];
  logic [3:0]            top_digit;

  assign carry[0]  = mag_q[ValueWidth-1];
  assign top_digit = dig[NumDigits-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    logic [3:0] lower;
    if (i == 0) begin : g_first
      assign lower = 4'd0;
    end else begin : g_rest
      assign lower = dig[i-1];
    end
    sbda_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .bit_i   (carry[i]),
      .digit_i (lower),
      .bit_o   (carry[i+1]),
      .digit_o (dig[i])
    );
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    cell_op  = CELL_HOLD;
    mag_d    = mag_q;
    bits_d   = bits_q;
    neg_d    = neg_q;
    rem_d    = rem_q;
    total_d  = total_q;
    strobe_d = 1'b0;
    load_out = 1'b0;
    char_d   = CharZero;
    last_d   = 1'b0;
    count_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          neg_d   = value_i[ValueWidth-1];
          mag_d   = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
          bits_d  = '0;
          cell_op = CELL_CLEAR;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cell_op = CELL_DABBLE;
        mag_d   = {mag_q[ValueWidth-2:0], 1'b0};
        bits_d  = bits_q + 1'b1;
        if (bits_q == BitCntW'(ValueWidth - 1)) begin
          rem_d   = CountW'(NumDigits);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit == 4'd0) && (rem_q > CountW'(1))) begin
          cell_op = CELL_MOVE;
          rem_d   = rem_q - 1'b1;
        end else begin
          total_d = rem_q + CountW'(neg_q);
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        strobe_d = 1'b1;
        load_out = 1'b1;
        char_d   = CharMinus;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        load_out = 1'b1;
        char_d   = CharZero + {4'd0, top_digit};
        cell_op  = CELL_MOVE;
        rem_d    = rem_q - 1'b1;
        if (rem_q == CountW'(1)) begin
          last_d  = 1'b1;
          count_d = total_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_o <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bits_q  <= bits_d;
    neg_q   <= neg_d;
    rem_q   <= rem_d;
    total_q <= total_d;
    if (load_out) begin
      char_code_o  <= char_d;
      last_o       <= last_d;
      char_count_o <= count_d;
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives signed 64-bit values into the decimal ascii printer with random
// request gaps, predicts the character stream of each request and checks
// every strobed character, last flag and count against it in order.
// ----------------------------------------------------------------------------
module testbench;
  import sbda_pkg::*;

  typedef struct packed {
    logic [7:0]        code;
    logic              is_last;
    logic [CountW-1:0] count;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // decimal text of one accepted request, minus sign first
    function void note_request(logic [ValueWidth-1:0] v);
      logic [ValueWidth-1:0] mag;
      logic [3:0]            digits[NumDigits];
      int                    nd;
      int                    total;
      int                    k;
      text_char_t            c;
      mag = v[ValueWidth-1] ? (~v + 64'd1) : v;
      digits[0] = 4'(mag % 64'd10);
      mag = mag / 64'd10;
      nd = 1;
      while (mag != 0 && nd < NumDigits) begin
        digits[nd] = 4'(mag % 64'd10);
        mag = mag / 64'd10;
        nd++;
      end
      total = nd + (v[ValueWidth-1] ? 1 : 0);
      k = 0;
      if (v[ValueWidth-1]) begin
        c.code = CharMinus;
        c.is_last = 1'b0;
        c.count = '0;
        pending_chars.push_back(c);
        k++;
      end
      for (int i = nd; i > 0; i--) begin
        c.code = CharZero + 8'(digits[i-1]);
        c.is_last = (k + 1 == total);
        c.count = c.is_last ? CountW'(total) : '0;
        pending_chars.push_back(c);
        k++;
      end
    endfunction

    function void report(string what, text_char_t want, text_char_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch (%s): expected code %0d last %0b count %0d,",
                 what, want.code, want.is_last, want.count);
        $display("  got code %0d last %0b count %0d",
                 got.code, got.is_last, got.count);
      end
    endfunction

    function void check_char(text_char_t got);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        want = '0;
        report("no character expected", want, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.code != want.code) report("char_code", want, got);
        else if (got.is_last != want.is_last) report("last", want, got);
        else if (got.count != want.count) report("char_count", want, got);
      end
    endfunction

    function void close_out();
      if (pending_chars.size() != 0) begin
        mismatches++;
        $display("%0d expected characters never arrived", pending_chars.size());
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ValueWidth-1:0] value_i = '0;
  logic                  strobe_o;
  logic [7:0]            char_code_o;
  logic                  last_o;
  logic [CountW-1:0]     char_count_o;

  text_scoreboard sb = new();

  signed_binary_to_decimal_ascii dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .strobe_o     (strobe_o),
    .char_code_o  (char_code_o),
    .last_o       (last_o),
    .char_count_o (char_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      sb.check_char({char_code_o, last_o, char_count_o});
    end
  end

  // one request, with a random number of idle cycles in front of it
  task automatic send_value(logic [ValueWidth-1:0] v);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (busy);
      repeat (gap - 1) @(posedge clk_i);
    end
    start <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    sb.note_request(v);
  endtask

  function automatic logic [ValueWidth-1:0] pow10(int n);
    logic [ValueWidth-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] v;
    int                    mode;
    mode = $urandom_range(0, 9);
    unique case (mode)
      0: begin
        v = 64'($urandom_range(0, 20));
      end
      1: begin
        v = pow10($urandom_range(1, 19)) + 64'($signed($urandom_range(0, 2)) - 1);
      end
      2: begin
        v = {1'b1, 63'd0} + 64'($urandom_range(0, 1000));
      end
      3: begin
        v = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 1000));
      end
      default: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
      end
    endcase
    if ($urandom_range(0, 1)) v = ~v + 64'd1;
    return v;
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'sd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(-64'sd10);
    send_value(64'd99);
    send_value(64'd100);
    send_value(-64'sd999);
    send_value({1'b0, {63{1'b1}}});
    send_value({1'b0, {62{1'b1}}, 1'b0});
    send_value({1'b1, 63'd0});
    send_value({1'b1, 62'd0, 1'b1});
    send_value(pow10(18));
    send_value(pow10(18) - 64'd1);
    send_value(~pow10(18) + 64'd1);
    send_value(~(pow10(18) - 64'd1) + 64'd1);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    send_value(pow10(9));

    for (int n = 0; n < 180; n++) begin
      send_value(random_value());
    end
    start <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
